// ----- rtl/pfr_pkg.sv -----
package pfr_pkg;

    localparam int unsigned PAYLOAD_DEPTH_DEF = 256;

    localparam logic [7:0] NODE_ADDRESS_RST = 8'd0;
    localparam logic [7:0] START_BYTE_RST   = 8'd2;
    localparam logic [7:0] ACK_BYTE_RST     = 8'd6;
    localparam logic [7:0] NACK_BYTE_RST    = 8'd21;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ADDR     = 3'd1,
        PH_LEN      = 3'd2,
        PH_DATA     = 3'd3,
        PH_VALIDATE = 3'd4,
        PH_FINISHED = 3'd5,
        PH_ERROR    = 3'd6,
        PH_ACK      = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        CMD_RECV  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_NODE_ADDRESS = 2'd0,
        REG_START_BYTE   = 2'd1,
        REG_ACK_BYTE     = 2'd2,
        REG_NACK_BYTE    = 2'd3
    } t_reg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0] frame_state;
        logic [7:0] payload_length;
        logic [7:0] rd_byte;
    } t_out_item;

endpackage

// ----- rtl/packet_frame_receiver_top.sv -----
// Addressed serial frame receiver: takes one item per clock when the output side keeps up
// (frame logic plus a payload memory with registered read). The result of each item is
// registered in a first pipeline register and then in a second before it is presented;
// the second lets a new item in while a finished result still waits to be taken.
// Frames are start byte, node address, length, payload and an 8-bit additive checksum;
// payload bytes are stored up to PAYLOAD_DEPTH and read back by index, a position not yet
// received reading as zero. Configuration writes are taken at any clock with the write
// enable high.
module packet_frame_receiver_top #(
    parameter int unsigned PAYLOAD_DEPTH = pfr_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pfr_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pfr_pkg::t_out_item  o_out_item
);

    localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [8:0] DEPTH9 = 9'(PAYLOAD_DEPTH);

    logic [7:0] r_node_address;
    logic [7:0] r_start_byte;
    logic [7:0] r_ack_byte;
    logic [7:0] r_nack_byte;

    pfr_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_byte_sum, n_byte_sum;
    logic [7:0] r_length, n_length;
    logic [7:0] r_count, n_count;

    logic [7:0] r_mem [PAYLOAD_DEPTH];
    logic [7:0] r_mem_q;

    logic            r_s1_valid;
    pfr_pkg::t_phase r_s1_phase;
    logic [7:0]      r_s1_length;
    logic            r_s1_rd_ok;

    logic                r_out_valid;
    pfr_pkg::t_out_item  r_out_item;

    logic       s1_adv;
    logic       accept;
    logic       wr_en;
    logic       rd_ok;
    logic [7:0] rx;
    logic [7:0] idx;
    logic [7:0] count_inc;
    pfr_pkg::t_cmd cmd;

    assign cmd       = pfr_pkg::t_cmd'(i_in_item.cmd);
    assign rx        = i_in_item.rx_byte;
    assign idx       = i_in_item.read_index;
    assign count_inc = r_count + 8'd1;

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address <= pfr_pkg::NODE_ADDRESS_RST;
            r_start_byte   <= pfr_pkg::START_BYTE_RST;
            r_ack_byte     <= pfr_pkg::ACK_BYTE_RST;
            r_nack_byte    <= pfr_pkg::NACK_BYTE_RST;
        end else if (i_cfg_we) begin
            unique case (pfr_pkg::t_reg'(i_cfg_index))
                pfr_pkg::REG_NODE_ADDRESS: r_node_address <= i_cfg_data;
                pfr_pkg::REG_START_BYTE:   r_start_byte   <= i_cfg_data;
                pfr_pkg::REG_ACK_BYTE:     r_ack_byte     <= i_cfg_data;
                pfr_pkg::REG_NACK_BYTE:    r_nack_byte    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        unique case (cmd)
            pfr_pkg::CMD_RECV: begin
                unique case (r_phase)
                    pfr_pkg::PH_IDLE: begin
                        if (rx == r_nack_byte) begin
                            n_phase = pfr_pkg::PH_ERROR;
                        end else if (rx == r_start_byte) begin
                            n_phase = pfr_pkg::PH_ADDR;
                        end
                        if (rx == r_ack_byte) begin
                            n_phase = pfr_pkg::PH_ACK;
                        end
                    end
                    pfr_pkg::PH_ADDR: begin
                        n_phase = (rx == r_node_address) ? pfr_pkg::PH_LEN : pfr_pkg::PH_IDLE;
                    end
                    pfr_pkg::PH_LEN: begin
                        n_phase = (rx == 8'd0) ? pfr_pkg::PH_VALIDATE : pfr_pkg::PH_DATA;
                    end
                    pfr_pkg::PH_DATA: begin
                        if (count_inc == r_length) begin
                            n_phase = pfr_pkg::PH_VALIDATE;
                        end
                    end
                    pfr_pkg::PH_VALIDATE: begin
                        n_phase = (r_byte_sum == rx) ? pfr_pkg::PH_FINISHED : pfr_pkg::PH_ERROR;
                    end
                    default: ;
                endcase
            end
            pfr_pkg::CMD_FLUSH: n_phase = pfr_pkg::PH_IDLE;
            default: ;
        endcase
    end

    // datapath next values, memory control and read qualification
    always_comb begin
        n_byte_sum = r_byte_sum;
        n_length   = r_length;
        n_count    = r_count;
        wr_en      = 1'b0;
        rd_ok      = 1'b0;
        unique case (cmd)
            pfr_pkg::CMD_RECV: begin
                unique case (r_phase)
                    pfr_pkg::PH_IDLE: begin
                        if (rx != r_nack_byte && rx == r_start_byte) begin
                            n_byte_sum = rx;
                            n_length   = 8'd0;
                            n_count    = 8'd0;
                        end
                    end
                    pfr_pkg::PH_ADDR: begin
                        if (rx == r_node_address) begin
                            n_byte_sum = r_byte_sum + rx;
                        end
                    end
                    pfr_pkg::PH_LEN: begin
                        n_length   = rx;
                        n_byte_sum = r_byte_sum + rx;
                    end
                    pfr_pkg::PH_DATA: begin
                        wr_en      = {1'b0, r_count} < DEPTH9;
                        n_byte_sum = r_byte_sum + rx;
                        n_count    = count_inc;
                    end
                    pfr_pkg::PH_VALIDATE: begin
                        n_byte_sum = r_byte_sum + rx;
                    end
                    default: ;
                endcase
            end
            pfr_pkg::CMD_READ: begin
                rd_ok = (idx < r_count) && ({1'b0, idx} < DEPTH9);
            end
            pfr_pkg::CMD_FLUSH: begin
                n_byte_sum = 8'd0;
                n_length   = 8'd0;
                n_count    = 8'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= pfr_pkg::PH_IDLE;
            r_byte_sum <= 8'd0;
            r_length   <= 8'd0;
            r_count    <= 8'd0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_byte_sum <= n_byte_sum;
            r_length   <= n_length;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem[r_count[AW-1:0]] <= rx;
        end
        if (accept) begin
            r_mem_q <= r_mem[idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_phase  <= n_phase;
            r_s1_length <= n_length;
            r_s1_rd_ok  <= rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_item.frame_state    <= r_s1_phase;
            r_out_item.payload_length <= r_s1_length;
            r_out_item.rd_byte        <= r_s1_rd_ok ? r_mem_q : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- rtl/pfr_checker.sv -----
module pfr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input pfr_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    a_addr_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_state == pfr_pkg::PH_ADDR
            |-> o_out_item.payload_length == 8'd0)
        else $error("length not cleared by start byte");

endmodule

bind packet_frame_receiver_top pfr_checker u_pfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [7:0]          cfg_data;
    logic                in_valid;
    logic                in_stall;
    pfr_pkg::t_in_item   in_item;
    logic                out_valid;
    logic                out_stall;
    pfr_pkg::t_out_item  out_item;

    packet_frame_receiver_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // predicted receiver state and register copies
    pfr_pkg::t_phase fr_phase;
    logic [7:0] fr_sum;
    logic [7:0] fr_len;
    logic [7:0] fr_count;
    logic [7:0] fr_payload [256];
    bit         fr_stored [256];
    logic [7:0] reg_node;
    logic [7:0] reg_start;
    logic [7:0] reg_ack;
    logic [7:0] reg_nack;

    pfr_pkg::t_out_item pending_results [$];
    logic [7:0] frame_body [$];

    int errors;
    int items_sent;
    int results_checked;
    int frames_sent;
    int frames_passed;
    int settings_used;
    bit quiet;
    int hold_off;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #(3_000_000);
        $display("packet_frame_receiver_top regression: fail");
        $finish;
    end

    function automatic pfr_pkg::t_out_item frame_result(pfr_pkg::t_in_item it);
        pfr_pkg::t_out_item r;
        logic [7:0] b;
        r = '0;
        b = it.rx_byte;
        case (it.cmd)
            pfr_pkg::CMD_RECV: begin
                case (fr_phase)
                    pfr_pkg::PH_IDLE: begin
                        if (b == reg_nack) begin
                            fr_phase = pfr_pkg::PH_ERROR;
                        end else if (b == reg_start) begin
                            fr_phase = pfr_pkg::PH_ADDR;
                            fr_sum   = b;
                            fr_len   = 8'd0;
                            fr_count = 8'd0;
                        end
                        if (b == reg_ack) fr_phase = pfr_pkg::PH_ACK;
                    end
                    pfr_pkg::PH_ADDR: begin
                        if (b == reg_node) begin
                            fr_sum   = fr_sum + b;
                            fr_phase = pfr_pkg::PH_LEN;
                        end else begin
                            fr_phase = pfr_pkg::PH_IDLE;
                        end
                    end
                    pfr_pkg::PH_LEN: begin
                        fr_len = b;
                        fr_sum = fr_sum + b;
                        if (b == 8'd0) fr_phase = pfr_pkg::PH_VALIDATE;
                        else fr_phase = pfr_pkg::PH_DATA;
                    end
                    pfr_pkg::PH_DATA: begin
                        fr_payload[fr_count] = b;
                        fr_stored[fr_count]  = 1'b1;
                        fr_sum   = fr_sum + b;
                        fr_count = fr_count + 8'd1;
                        if (fr_count == fr_len) fr_phase = pfr_pkg::PH_VALIDATE;
                    end
                    pfr_pkg::PH_VALIDATE: begin
                        if (fr_sum == b) fr_phase = pfr_pkg::PH_FINISHED;
                        else fr_phase = pfr_pkg::PH_ERROR;
                        fr_sum = fr_sum + b;
                    end
                    default: ;
                endcase
            end
            pfr_pkg::CMD_READ: begin
                if (it.read_index < fr_count) r.rd_byte = fr_payload[it.read_index];
            end
            pfr_pkg::CMD_FLUSH: begin
                fr_phase = pfr_pkg::PH_IDLE;
                fr_sum   = 8'd0;
                fr_len   = 8'd0;
                fr_count = 8'd0;
            end
            default: ;
        endcase
        r.frame_state    = fr_phase;
        r.payload_length = fr_len;
        return r;
    endfunction

    function automatic logic [7:0] stored_index();
        logic [7:0] idx;
        do idx = 8'($urandom); while (!fr_stored[idx]);
        return idx;
    endfunction

    task automatic send_item(pfr_pkg::t_cmd c, logic [7:0] rx, logic [7:0] idx);
        pfr_pkg::t_in_item it;
        it.cmd        = c;
        it.rx_byte    = rx;
        it.read_index = idx;
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 13) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.push_back(frame_result(it));
        items_sent++;
    endtask

    task automatic put_byte(logic [7:0] b);
        send_item(pfr_pkg::CMD_RECV, b, 8'($urandom));
    endtask

    task automatic read_back(logic [7:0] idx);
        send_item(pfr_pkg::CMD_READ, 8'($urandom), idx);
    endtask

    task automatic flush_frame();
        send_item(pfr_pkg::CMD_FLUSH, 8'($urandom), 8'($urandom));
    endtask

    // start, address, length, frame_body, checksum
    task automatic send_frame(bit bad_addr, bit bad_sum, bit reads_mid);
        logic [7:0] sum;
        logic [7:0] addr;
        addr = reg_node;
        if (bad_addr) addr = addr + 8'($urandom_range(1, 255));
        sum = reg_start + addr + 8'(frame_body.size());
        put_byte(reg_start);
        put_byte(addr);
        put_byte(8'(frame_body.size()));
        foreach (frame_body[i]) begin
            sum = sum + frame_body[i];
            put_byte(frame_body[i]);
            if (reads_mid && $urandom_range(0, 3) == 0) read_back(stored_index());
        end
        if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
        put_byte(sum);
        frames_sent++;
        if (fr_phase == pfr_pkg::PH_FINISHED) frames_passed++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(pfr_pkg::t_reg r, logic [7:0] v);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (r)
            pfr_pkg::REG_NODE_ADDRESS: reg_node  = v;
            pfr_pkg::REG_START_BYTE:   reg_start = v;
            pfr_pkg::REG_ACK_BYTE:     reg_ack   = v;
            default:                   reg_nack  = v;
        endcase
    endtask

    task automatic configure(logic [7:0] node, start, ack, nack);
        set_reg(pfr_pkg::REG_NODE_ADDRESS, node);
        set_reg(pfr_pkg::REG_START_BYTE, start);
        set_reg(pfr_pkg::REG_ACK_BYTE, ack);
        set_reg(pfr_pkg::REG_NACK_BYTE, nack);
        settings_used++;
    endtask

    task automatic random_markers(output logic [7:0] start, ack, nack);
        start = 8'($urandom);
        do ack = 8'($urandom); while (ack == start);
        do nack = 8'($urandom); while (nack == start || nack == ack);
    endtask

    task automatic test_basic_frame();
        frame_body = {8'hFF, 8'h00, 8'h80};
        send_frame(1'b0, 1'b0, 1'b0);
        read_back(8'd0);
        read_back(8'd2);
        put_byte(8'hFF);
        send_item(pfr_pkg::CMD_NONE, 8'h00, 8'hFF);
        flush_frame();
        // zero length goes straight to the checksum
        frame_body = {};
        send_frame(1'b0, 1'b0, 1'b0);
        read_back(8'd0);
        flush_frame();
    endtask

    task automatic test_error_paths();
        frame_body = {};
        send_frame(1'b0, 1'b1, 1'b0);
        flush_frame();
        put_byte(reg_start);
        put_byte(reg_node + 8'd1);
        put_byte(reg_ack);
        flush_frame();
        put_byte(reg_nack);
        flush_frame();
    endtask

    task automatic test_marker_overlap();
        configure(8'd0, 8'd5, 8'd6, 8'd5);
        put_byte(8'd5);
        flush_frame();
        configure(8'd0, 8'd9, 8'd9, 8'd21);
        put_byte(8'd9);
        flush_frame();
        configure(8'd0, 8'd0, 8'd0, 8'd0);
        put_byte(8'd0);
        flush_frame();
        configure(8'd0, 8'd2, 8'h33, 8'h33);
        put_byte(8'h33);
        flush_frame();
    endtask

    task automatic test_long_frame();
        configure(8'hFF, 8'h00, 8'hFF, 8'h80);
        frame_body = {};
        repeat (255) frame_body.push_back(8'($urandom));
        send_frame(1'b0, 1'b0, 1'b0);
        read_back(8'd254);
        read_back(8'd0);
        read_back(8'd128);
        flush_frame();
    endtask

    task automatic test_backpressure();
        settle();
        hold_off = 80;
        repeat (3) begin
            frame_body = {};
            repeat (8) frame_body.push_back(8'($urandom));
            send_frame(1'b0, 1'b0, 1'b0);
            read_back(stored_index());
            flush_frame();
        end
        settle();
    endtask

    task automatic test_random_traffic(logic [7:0] node, start, ack, nack, int n_items);
        int   stop_at;
        int   sel;
        int   len;
        pfr_pkg::t_cmd c;
        configure(node, start, ack, nack);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if (fr_phase != pfr_pkg::PH_IDLE && $urandom_range(0, 9) != 0) flush_frame();
            sel = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            frame_body = {};
            repeat (len) frame_body.push_back(8'($urandom));
            if (sel < 70) begin
                send_frame(1'b0, sel >= 60, 1'b1);
                repeat ($urandom_range(0, 3)) read_back(stored_index());
                if ($urandom_range(0, 3) == 0) put_byte(8'($urandom));
            end else if (sel < 78) begin
                send_frame(1'b1, 1'b0, 1'b0);
            end else if (sel < 84) begin
                put_byte($urandom_range(0, 1) ? ack : nack);
                put_byte(8'($urandom));
            end else if (sel < 92) begin
                // cut short by a flush
                put_byte(start);
                put_byte(node);
                put_byte(8'(len + 2));
                repeat ($urandom_range(0, len + 1)) put_byte(8'($urandom));
                flush_frame();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    c = pfr_pkg::t_cmd'($urandom_range(0, 3));
                    if (c == pfr_pkg::CMD_READ) read_back(stored_index());
                    else send_item(c, 8'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off > 0) begin
                out_stall <= 1'b1;
                hold_off--;
            end else begin
                out_stall <= !quiet && ($urandom_range(0, 99) < 13);
            end
        end
    end

    always @(posedge clk) begin : check_results
        pfr_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, expected none, got %p", $time, out_item);
                errors++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (out_item.frame_state !== want.frame_state) begin
                    $display("%0t: frame_state expected %0d got %0d", $time,
                             want.frame_state, out_item.frame_state);
                    errors++;
                end
                if (out_item.payload_length !== want.payload_length) begin
                    $display("%0t: payload_length expected %0d got %0d", $time,
                             want.payload_length, out_item.payload_length);
                    errors++;
                end
                if (out_item.rd_byte !== want.rd_byte) begin
                    $display("%0t: rd_byte expected %0d got %0d", $time,
                             want.rd_byte, out_item.rd_byte);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [7:0] m_start;
        logic [7:0] m_ack;
        logic [7:0] m_nack;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = pfr_pkg::REG_NODE_ADDRESS;
        cfg_data  = 8'd0;
        in_valid  = 1'b0;
        in_item   = '0;
        quiet     = 1'b0;
        hold_off  = 0;
        errors    = 0;
        reg_node  = pfr_pkg::NODE_ADDRESS_RST;
        reg_start = pfr_pkg::START_BYTE_RST;
        reg_ack   = pfr_pkg::ACK_BYTE_RST;
        reg_nack  = pfr_pkg::NACK_BYTE_RST;
        fr_phase  = pfr_pkg::PH_IDLE;
        fr_sum    = 8'd0;
        fr_len    = 8'd0;
        fr_count  = 8'd0;
        foreach (fr_stored[i]) fr_stored[i] = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_frame();
        test_error_paths();
        test_marker_overlap();
        test_long_frame();
        test_backpressure();
        test_random_traffic(8'h00, 8'hFF, 8'h00, 8'h01, 230);
        test_random_traffic(8'hFF, 8'h00, 8'hFF, 8'hFE, 230);
        random_markers(m_start, m_ack, m_nack);
        quiet = 1'b1;
        test_random_traffic(8'($urandom), m_start, m_ack, m_nack, 230);
        quiet = 1'b0;
        random_markers(m_start, m_ack, m_nack);
        test_random_traffic(8'($urandom), m_start, m_ack, m_nack, 230);

        settle();
        repeat (10) @(posedge clk);
        $display("ran %0d items and %0d frames (%0d good) across %0d marker settings",
                 items_sent, frames_sent, frames_passed, settings_used);
        $display("%0d results compared, %0d mismatches", results_checked, errors);
        if (errors == 0) begin
            $display("packet_frame_receiver_top regression: pass");
        end else begin
            $display("packet_frame_receiver_top regression: fail");
        end
        $finish;
    end

endmodule
